>>> hdl/fdct_8x8_fast_integer_assert.svh
// Assertion helpers for the DCT block
`ifndef FDCT_8X8_FAST_INTEGER_ASSERT_SVH
`define FDCT_8X8_FAST_INTEGER_ASSERT_SVH

// same-cycle implication
`define FDCT_ASSERT_IMPL(label, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("fdct assertion failed");

// next-cycle implication
`define FDCT_ASSERT_NEXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("fdct assertion failed");

`endif

>>> hdl/fdct_pkg.sv
`default_nettype none
package fdct_pkg;
  localparam int DW = 22;
  typedef logic signed [DW-1:0] data_t;
  typedef logic signed [9:0] coef_t;

  localparam coef_t C_0_382 = 10'sd98;
  localparam coef_t C_0_541 = 10'sd139;
  localparam coef_t C_0_707 = 10'sd181;
  localparam coef_t C_1_306 = 10'sd334;
  localparam data_t LEVEL_OFFSET = 22'sd1024;

  typedef struct packed {
    logic       ld_en;
    logic [2:0] ld_idx;
    logic       go;
    logic       dc_en;
  } aan_cmd_t;
endpackage
`default_nettype wire

>>> hdl/fdct_8x8_fast_integer.sv
`default_nettype none
// 8x8 forward DCT, fast integer (AAN) flow.
// Input: in_valid/in_ready carry one 8-bit pixel word per accepted cycle, row-major.
// in_ready is high while a block is being collected, one word per cycle.
// After the 64th pixel the block is transformed: 8 row passes from the pixel
// memory into a work memory, then 8 column passes in place there, each pass
// loading, running the shared multiplier unit and writing back; no input is taken.
// The 64 coefficients then leave on out_valid/out_ready in natural order,
// out_last on index 63; each word is read from memory, then held until taken.
// A stalled receiver holds the current word; nothing is dropped.
// After the last coefficient is taken, in_ready returns the next cycle.
// Reset (rst_n low, synchronous) returns to collecting with an empty block.
module fdct_8x8_fast_integer (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         in_pixel,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      out_coefficient,
  output logic [5:0]              out_coeff_index,
  output logic                    out_last
);
  import fdct_pkg::*;

  localparam logic [2:0] ST_FILL  = 3'd0;
  localparam logic [2:0] ST_LOAD  = 3'd1;
  localparam logic [2:0] ST_WAIT  = 3'd2;
  localparam logic [2:0] ST_STORE = 3'd3;
  localparam logic [2:0] ST_RD    = 3'd4;
  localparam logic [2:0] ST_SEND  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic [3:0] pass_r, pass_nxt;
  logic [3:0] k_r, k_nxt;

  logic [7:0]         sample_mem [64];
  logic signed [15:0] work_mem [64];
  logic [7:0]         srd_r;
  logic signed [15:0] wrd_r;
  logic [5:0]         pass_addr, rd_addr;
  logic [2:0]         kk;
  logic               in_acc, out_acc, done;
  aan_cmd_t           cmd;
  logic signed [15:0] ld_data, y_data;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;
  assign kk      = (state_r == ST_LOAD) ? k_r[2:0] : k_r[2:0];
  assign pass_addr = pass_r[3] ? {kk, pass_r[2:0]} : {pass_r[2:0], kk};
  assign rd_addr   = (state_r == ST_LOAD) ? pass_addr : cnt_r;

  always_ff @(posedge clk) begin
    if (state_r == ST_FILL && in_acc) sample_mem[cnt_r] <= in_pixel;
    if (state_r == ST_STORE) work_mem[pass_addr] <= y_data;
    srd_r <= sample_mem[rd_addr];
    wrd_r <= work_mem[rd_addr];
  end

  assign ld_data = pass_r[3] ? wrd_r : $signed({8'd0, srd_r});

  always_comb begin
    cmd.ld_en  = (state_r == ST_LOAD) && (k_r != 4'd0);
    cmd.ld_idx = 3'(k_r - 4'd1);
    cmd.go     = (state_r == ST_LOAD) && (k_r == 4'd8);
    cmd.dc_en  = !pass_r[3];
  end

  fdct_aan1d u_aan (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .ld_data (ld_data),
    .rd_idx  (k_r[2:0]),
    .y_data  (y_data),
    .done    (done)
  );

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    pass_nxt  = pass_r;
    k_nxt     = k_r;
    unique case (state_r)
      ST_FILL: if (in_acc) begin
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          state_nxt = ST_LOAD;
          pass_nxt  = '0;
          k_nxt     = '0;
        end
      end
      ST_LOAD: begin
        if (k_r == 4'd8) begin
          state_nxt = ST_WAIT;
          k_nxt     = '0;
        end else begin
          k_nxt = k_r + 4'd1;
        end
      end
      ST_WAIT: if (done) state_nxt = ST_STORE;
      ST_STORE: begin
        k_nxt = k_r + 4'd1;
        if (k_r == 4'd7) begin
          k_nxt = '0;
          if (pass_r == 4'd15) begin
            state_nxt = ST_RD;
            cnt_nxt   = '0;
          end else begin
            pass_nxt  = pass_r + 4'd1;
            state_nxt = ST_LOAD;
          end
        end
      end
      ST_RD: state_nxt = ST_SEND;
      ST_SEND: if (out_acc) begin
        cnt_nxt   = cnt_r + 6'd1;
        state_nxt = (cnt_r == 6'd63) ? ST_FILL : ST_RD;
      end
      default: state_nxt = ST_FILL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_FILL;
      cnt_r   <= '0;
      pass_r  <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pass_r  <= pass_nxt;
      k_r     <= k_nxt;
    end
  end

  assign in_ready        = (state_r == ST_FILL);
  assign out_valid       = (state_r == ST_SEND);
  assign out_coefficient = wrd_r;
  assign out_coeff_index = cnt_r;
  assign out_last        = (cnt_r == 6'd63);

`include "fdct_8x8_fast_integer_assert.svh"
  `FDCT_ASSERT_IMPL(a_no_overlap, out_valid, !in_ready)
  `FDCT_ASSERT_NEXT(a_fill_end, in_acc && cnt_r == 6'd63, !in_ready)
  `FDCT_ASSERT_NEXT(a_block_end, out_acc && out_last, in_ready)
  `FDCT_ASSERT_NEXT(a_unit_done, state_r == ST_WAIT && done, state_r == ST_STORE)
endmodule
`default_nettype wire

>>> hdl/fdct_aan1d.sv
`default_nettype none
module fdct_aan1d (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire fdct_pkg::aan_cmd_t  cmd,
  input  wire logic signed [15:0]  ld_data,
  input  wire logic [2:0]          rd_idx,
  output logic signed [15:0]       y_data,
  output logic                     done
);
  import fdct_pkg::*;

  localparam logic [2:0] U_IDLE = 3'd0;
  localparam logic [2:0] U_BUT  = 3'd1;
  localparam logic [2:0] U_M0   = 3'd2;
  localparam logic [2:0] U_M1   = 3'd3;
  localparam logic [2:0] U_M2   = 3'd4;
  localparam logic [2:0] U_M3   = 3'd5;
  localparam logic [2:0] U_M4   = 3'd6;
  localparam logic [2:0] U_Y    = 3'd7;

  logic [2:0] st_r, st_nxt;
  data_t x_r [8];
  data_t y_r [8];
  data_t e0_r, e1_r, e2_r, e3_r, a_r, b_r, c_r, d07_r;
  data_t r_r, rot_r, ka_r, kc_r, mb_r;
  logic  dc_r;
  data_t op;
  coef_t k;
  logic signed [DW+9:0] prod;
  data_t sh;
  data_t ka, kc, hi, lo;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      U_IDLE:  if (cmd.go) st_nxt = U_BUT;
      U_Y:     st_nxt = U_IDLE;
      default: st_nxt = st_r + 3'd1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= U_IDLE;
    else st_r <= st_nxt;
  end

  // shared constant multiplier, floor shift of 8
  always_comb begin
    unique case (st_r)
      U_M0:    begin op = e2_r + e3_r; k = C_0_707; end
      U_M1:    begin op = a_r - c_r;   k = C_0_382; end
      U_M2:    begin op = a_r;         k = C_0_541; end
      U_M3:    begin op = c_r;         k = C_1_306; end
      default: begin op = b_r;         k = C_0_707; end
    endcase
    prod = op * k;
    sh   = data_t'(prod >>> 8);
    ka   = ka_r + rot_r;
    kc   = kc_r + rot_r;
    hi   = d07_r + mb_r;
    lo   = d07_r - mb_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_en) x_r[cmd.ld_idx] <= data_t'(ld_data);
    if (cmd.go) dc_r <= cmd.dc_en;
    unique case (st_r)
      U_BUT: begin
        e0_r  <= (x_r[0] + x_r[7]) + (x_r[3] + x_r[4]);
        e3_r  <= (x_r[0] + x_r[7]) - (x_r[3] + x_r[4]);
        e1_r  <= (x_r[1] + x_r[6]) + (x_r[2] + x_r[5]);
        e2_r  <= (x_r[1] + x_r[6]) - (x_r[2] + x_r[5]);
        a_r   <= (x_r[3] - x_r[4]) + (x_r[2] - x_r[5]);
        b_r   <= (x_r[2] - x_r[5]) + (x_r[1] - x_r[6]);
        c_r   <= (x_r[1] - x_r[6]) + (x_r[0] - x_r[7]);
        d07_r <= x_r[0] - x_r[7];
      end
      U_M0: r_r   <= sh;
      U_M1: rot_r <= sh;
      U_M2: ka_r  <= sh;
      U_M3: kc_r  <= sh;
      U_M4: mb_r  <= sh;
      U_Y: begin
        y_r[0] <= e0_r + e1_r - (dc_r ? LEVEL_OFFSET : '0);
        y_r[4] <= e0_r - e1_r;
        y_r[2] <= e3_r + r_r;
        y_r[6] <= e3_r - r_r;
        y_r[5] <= lo + ka;
        y_r[3] <= lo - ka;
        y_r[1] <= hi + kc;
        y_r[7] <= hi - kc;
      end
      default: ;
    endcase
  end

  assign y_data = y_r[rd_idx][15:0];
  assign done   = (st_r == U_Y);
endmodule
`default_nettype wire

>>> sim/tb_fdct_8x8_fast_integer.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_fdct_8x8_fast_integer;
  localparam int N_BLOCKS_RAND = 2;   // 448 pixel words with the directed blocks

  typedef struct {
    logic signed [15:0] coef;
    logic [5:0]         idx;
    logic               last;
  } coef_word_t;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [7:0] in_pixel;
  logic signed [15:0] out_coefficient;
  logic [5:0] out_coeff_index;
  logic out_last;

  fdct_8x8_fast_integer u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_pixel(in_pixel),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_coefficient(out_coefficient), .out_coeff_index(out_coeff_index),
    .out_last(out_last)
  );

  // predictor state
  logic [7:0] pix_buf [64];
  int unsigned pix_cnt;
  coef_word_t coef_q[$];
  int errors, words_seen, blocks_sent;
  bit no_idle;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic longint fix_mul(longint v, longint c);
    return (v * c) >>> 8;   // arithmetic shift floors
  endfunction

  function automatic void aan_pass(input longint x[8], output longint y[8], input longint dc);
    longint s07, d07, s16, d16, s25, d25, s34, d34, e0, e1, e2, e3, r;
    longint a, b, c, rot, ka, kc, mb, hi, lo;
    s07 = x[0] + x[7]; d07 = x[0] - x[7];
    s16 = x[1] + x[6]; d16 = x[1] - x[6];
    s25 = x[2] + x[5]; d25 = x[2] - x[5];
    s34 = x[3] + x[4]; d34 = x[3] - x[4];
    e0 = s07 + s34; e3 = s07 - s34;
    e1 = s16 + s25; e2 = s16 - s25;
    y[0] = e0 + e1 - dc;
    y[4] = e0 - e1;
    r = fix_mul(e2 + e3, 181);
    y[2] = e3 + r;
    y[6] = e3 - r;
    a = d34 + d25; b = d25 + d16; c = d16 + d07;
    rot = fix_mul(a - c, 98);
    ka = fix_mul(a, 139) + rot;
    kc = fix_mul(c, 334) + rot;
    mb = fix_mul(b, 181);
    hi = d07 + mb; lo = d07 - mb;
    y[5] = lo + ka; y[3] = lo - ka;
    y[1] = hi + kc; y[7] = hi - kc;
  endfunction

  function automatic void predict_block();
    longint work[64];
    longint x[8], y[8];
    coef_word_t w;
    for (int i = 0; i < 8; i++) begin
      for (int k = 0; k < 8; k++) x[k] = longint'(pix_buf[i*8+k]);
      aan_pass(x, y, 1024);
      for (int k = 0; k < 8; k++) work[i*8+k] = y[k];
    end
    for (int i = 0; i < 8; i++) begin
      for (int k = 0; k < 8; k++) x[k] = work[k*8+i];
      aan_pass(x, y, 0);
      for (int k = 0; k < 8; k++) work[k*8+i] = y[k];
    end
    for (int k = 0; k < 64; k++) begin
      w.coef = work[k][15:0];
      w.idx = 6'(k);
      w.last = (k == 63);
      coef_q.push_back(w);
    end
  endfunction

  function automatic void accept_pixel(logic [7:0] p);
    pix_buf[pix_cnt] = p;
    if (pix_cnt == 63) begin
      pix_cnt = 0;
      blocks_sent++;
      predict_block();
    end else
      pix_cnt++;
  endfunction

  // directed table: one pattern per block
  typedef enum int {PAT_FLAT_LO, PAT_FLAT_HI, PAT_FLAT_MID, PAT_CHECKER, PAT_RAMP} pat_t;
  pat_t dir_tab[5] = '{PAT_FLAT_LO, PAT_FLAT_HI, PAT_FLAT_MID, PAT_CHECKER, PAT_RAMP};

  function automatic logic [7:0] pat_pixel(pat_t p, int n);
    case (p)
      PAT_FLAT_LO:  return 8'd0;
      PAT_FLAT_HI:  return 8'd255;
      PAT_FLAT_MID: return 8'd128;
      PAT_CHECKER:  return ((n / 8 + n) % 2) ? 8'd255 : 8'd0;
      default:      return 8'(n * 4);
    endcase
  endfunction

  // valid drops only while idling; the caller drops it after the last word
  task automatic send_pixel(logic [7:0] p);
    if (!no_idle) begin
      while ($urandom_range(99) < 18) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    in_pixel <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    accept_pixel(p);
    @(negedge clk);
  endtask

  // output side: random stall, check at rising edge
  always @(negedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 18);
  end

  always @(posedge clk) begin
    coef_word_t e;
    if (rst_n && out_valid && out_ready) begin
      words_seen++;
      if (coef_q.size() == 0) begin
        $display("%0t: unexpected word coef=%0d idx=%0d", $time, out_coefficient,
                 out_coeff_index);
        errors++;
      end else begin
        e = coef_q.pop_front();
        if (out_coefficient !== e.coef || out_coeff_index !== e.idx
            || out_last !== e.last)
          begin
          $display("%0t: mismatch exp coef=%0d idx=%0d last=%0b got coef=%0d idx=%0d last=%0b",
                   $time, e.coef, e.idx, e.last, out_coefficient, out_coeff_index, out_last);
          errors++;
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int mode;
    rst_n = 0; in_valid = 0; in_pixel = 0; out_ready = 0;
    pix_cnt = 0; errors = 0; words_seen = 0; blocks_sent = 0; no_idle = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed blocks; flat black block is read off by hand: DC -8192, rest 0
    for (int b = 0; b < 5; b++) begin
      for (int n = 0; n < 64; n++) send_pixel(pat_pixel(dir_tab[b], n));
      if (b == 0) begin
        if (coef_q[0].coef !== -16'sd8192 || coef_q[1].coef !== 16'sd0) begin
          $display("%0t: black block DC exp -8192 got %0d", $time, coef_q[0].coef);
          errors++;
        end
      end
    end
    in_valid <= 1'b0;
    // sender holds off until everything is drained
    wait (coef_q.size() == 0);

    for (int b = 0; b < N_BLOCKS_RAND; b++) begin
      mode = $urandom_range(2);
      no_idle = (b == 1);
      for (int n = 0; n < 64; n++)
        case (mode)
          0: send_pixel(8'($urandom_range(255)));
          1: send_pixel($urandom_range(1) ? 8'd255 : 8'd0);
          default: send_pixel(8'(8'd100 + $urandom_range(20)));
        endcase
    end
    in_valid <= 1'b0;
    no_idle = 0;
    wait (coef_q.size() == 0);
    repeat (600) @(posedge clk);
    $display("Run: %0d blocks of 64 pixel words, %0d coefficient words checked",
             blocks_sent, words_seen);
    if (errors == 0 && coef_q.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end
endmodule
`default_nettype wire

>>> fdct_8x8_fast_integer.f
+incdir+hdl
hdl/fdct_pkg.sv
hdl/fdct_aan1d.sv
hdl/fdct_8x8_fast_integer.sv
sim/tb_fdct_8x8_fast_integer.sv
